// ===== hdl/asbm_pkg.sv =====
// ----------------------------------------------------------------------------
// asbm_pkg
// Shared types and constants for the addressed serial bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package asbm_pkg;

  localparam logic [2:0] ACT_ADDR_ONLY  = 3'd0;
  localparam logic [2:0] ACT_WRITE_BYTE = 3'd1;
  localparam logic [2:0] ACT_WRITE_WORD = 3'd2;
  localparam logic [2:0] ACT_READ_BYTE  = 3'd3;
  localparam logic [2:0] ACT_READ_WORD  = 3'd4;

  localparam logic [4:0] BITS_ADDR_ONLY  = 5'd8;
  localparam logic [4:0] BITS_WRITE_BYTE = 5'd16;
  localparam logic [4:0] BITS_WRITE_WORD = 5'd24;
  localparam logic [4:0] BITS_READ_BYTE  = 5'd8;
  localparam logic [4:0] BITS_READ_WORD  = 5'd16;

  typedef struct packed {
    logic        start_req;
    logic [2:0]  action;
    logic [7:0]  address;
    logic [15:0] write_data;
    logic        data_in_pin;
  } in_item_t;

  typedef struct packed {
    logic        start_ok;
    logic [2:0]  action;
    logic [23:0] load_shift;
    logic [4:0]  load_bits;
    logic        data_in_pin;
  } fe_item_t;

  typedef struct packed {
    logic        select_n;
    logic        serial_clock;
    logic        data_out_pin;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_TX_LOW  = 5'b00010,
    PH_TX_HIGH = 5'b00100,
    PH_RX_LOW  = 5'b01000,
    PH_RX_HIGH = 5'b10000
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/asbm_front.sv =====
// ----------------------------------------------------------------------------
// asbm_front
// Accepts items, decodes the request and preloads the send word, and holds
// them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module asbm_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire asbm_pkg::in_item_t in_item,
  output logic                    q_valid,
  output asbm_pkg::fe_item_t      q_item,
  input  wire logic               q_pop
);

  asbm_pkg::fe_item_t entries [2];
  asbm_pkg::fe_item_t classified;
  logic [1:0]         count;
  logic               wr_ptr;
  logic               rd_ptr;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    classified.start_ok    = in_item.start_req && (in_item.action <= asbm_pkg::ACT_READ_WORD);
    classified.action      = in_item.action;
    classified.data_in_pin = in_item.data_in_pin;
    case (in_item.action)
      asbm_pkg::ACT_WRITE_BYTE: begin
        classified.load_shift = {in_item.address, in_item.write_data[7:0], 8'h00};
        classified.load_bits  = asbm_pkg::BITS_WRITE_BYTE;
      end
      asbm_pkg::ACT_WRITE_WORD: begin
        classified.load_shift = {in_item.address, in_item.write_data};
        classified.load_bits  = asbm_pkg::BITS_WRITE_WORD;
      end
      default: begin
        classified.load_shift = {in_item.address, 16'h0000};
        classified.load_bits  = asbm_pkg::BITS_ADDR_ONLY;
      end
    endcase
  end

  assign full    = count[1];
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/asbm_back.sv =====
// ----------------------------------------------------------------------------
// asbm_back
// Frame sequencer: steps the bus state once per queued item and writes one
// result per item into a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module asbm_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire asbm_pkg::fe_item_t q_item,
  output logic                    q_pop,
  output logic                    empty,
  input  wire logic               pop,
  output asbm_pkg::out_item_t     res
);

  asbm_pkg::phase_t    phase;
  asbm_pkg::phase_t    phase_next;
  logic [4:0]          bits_left;
  logic [4:0]          bits_left_next;
  logic [23:0]         send_shift;
  logic [23:0]         send_shift_next;
  logic [15:0]         receive_shift;
  logic [15:0]         receive_shift_next;
  logic [2:0]          held_action;
  logic [2:0]          held_action_next;
  logic                clock_level;
  logic                clock_level_next;
  logic                data_bit;
  logic                done;
  logic [15:0]         rd;
  logic [4:0]          bits_dec;
  logic [23:0]         send_shifted;
  logic [15:0]         recv_shifted;
  asbm_pkg::out_item_t result;

  asbm_pkg::out_item_t entries [2];
  logic [1:0]          count;
  logic                wr_ptr;
  logic                rd_ptr;
  logic                out_full;
  logic                do_pop;

  assign out_full = count[1];
  assign q_pop    = q_valid && !out_full;
  assign bits_dec = bits_left - 5'd1;
  assign send_shifted = {send_shift[22:0], 1'b0};
  assign recv_shifted = {receive_shift[14:0], q_item.data_in_pin};

  always_comb begin
    phase_next         = phase;
    bits_left_next     = bits_left;
    send_shift_next    = send_shift;
    receive_shift_next = receive_shift;
    held_action_next   = held_action;
    clock_level_next   = clock_level;
    data_bit           = 1'b0;
    done               = 1'b0;
    rd                 = 16'h0000;
    case (phase)
      asbm_pkg::PH_TX_LOW: begin
        phase_next       = asbm_pkg::PH_TX_HIGH;
        clock_level_next = 1'b1;
        data_bit         = send_shift[23];
      end
      asbm_pkg::PH_TX_HIGH: begin
        send_shift_next = send_shifted;
        bits_left_next  = bits_dec;
        if (bits_dec != 5'd0) begin
          phase_next       = asbm_pkg::PH_TX_LOW;
          clock_level_next = 1'b0;
          data_bit         = send_shifted[23];
        end else if (held_action == asbm_pkg::ACT_READ_BYTE ||
                     held_action == asbm_pkg::ACT_READ_WORD) begin
          bits_left_next   = (held_action == asbm_pkg::ACT_READ_BYTE) ?
                             asbm_pkg::BITS_READ_BYTE : asbm_pkg::BITS_READ_WORD;
          phase_next       = asbm_pkg::PH_RX_LOW;
          clock_level_next = 1'b0;
        end else begin
          phase_next       = asbm_pkg::PH_IDLE;
          clock_level_next = 1'b1;
          bits_left_next   = 5'd0;
          done             = 1'b1;
        end
      end
      asbm_pkg::PH_RX_LOW: begin
        phase_next       = asbm_pkg::PH_RX_HIGH;
        clock_level_next = 1'b1;
      end
      asbm_pkg::PH_RX_HIGH: begin
        receive_shift_next = recv_shifted;
        bits_left_next     = bits_dec;
        if (bits_dec != 5'd0) begin
          phase_next       = asbm_pkg::PH_RX_LOW;
          clock_level_next = 1'b0;
        end else begin
          phase_next       = asbm_pkg::PH_IDLE;
          clock_level_next = 1'b1;
          bits_left_next   = 5'd0;
          done             = 1'b1;
          rd               = recv_shifted;
        end
      end
      default: begin
        phase_next       = asbm_pkg::PH_IDLE;
        clock_level_next = 1'b1;
        if (q_item.start_ok) begin
          held_action_next   = q_item.action;
          receive_shift_next = 16'h0000;
          send_shift_next    = q_item.load_shift;
          bits_left_next     = q_item.load_bits;
          phase_next         = asbm_pkg::PH_TX_LOW;
          clock_level_next   = 1'b0;
          data_bit           = q_item.load_shift[23];
        end
      end
    endcase
    result.select_n     = (phase_next == asbm_pkg::PH_IDLE);
    result.serial_clock = clock_level_next;
    result.data_out_pin = data_bit;
    result.busy_res     = (phase_next != asbm_pkg::PH_IDLE);
    result.done_res     = done;
    result.read_data    = rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= asbm_pkg::PH_IDLE;
      bits_left     <= 5'd0;
      send_shift    <= 24'h000000;
      receive_shift <= 16'h0000;
      held_action   <= asbm_pkg::ACT_ADDR_ONLY;
      clock_level   <= 1'b1;
    end else if (q_pop) begin
      phase         <= phase_next;
      bits_left     <= bits_left_next;
      send_shift    <= send_shift_next;
      receive_shift <= receive_shift_next;
      held_action   <= held_action_next;
      clock_level   <= clock_level_next;
    end
  end

  assign empty  = (count == 2'd0);
  assign res    = entries[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      entries[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (q_pop) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({q_pop, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/addressed_serial_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// addressed_serial_bus_master_unit
// Each item passes through the input queue and then the result queue before its result is on the result ports.
// Throughput: one item per cycle while the result side is not stalled, set by the single-step frame sequencer.
// Each side has a two-entry queue, so a stalled result side does not block
// input until both queues fill.
// Reset: synchronous; both queues empty, the sequencer idle with the clock high.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_serial_bus_master_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        start_req,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  address,
  input  wire logic [15:0] write_data,
  input  wire logic        data_in_pin,
  output logic             empty,
  input  wire logic        pop,
  output logic             select_n,
  output logic             serial_clock,
  output logic             data_out_pin,
  output logic             busy_res,
  output logic             done_res,
  output logic [15:0]      read_data
);

  asbm_pkg::in_item_t  in_item;
  asbm_pkg::fe_item_t  q_item;
  asbm_pkg::out_item_t res;
  logic                q_valid;
  logic                q_pop;

  assign in_item.start_req   = start_req;
  assign in_item.action      = action;
  assign in_item.address     = address;
  assign in_item.write_data  = write_data;
  assign in_item.data_in_pin = data_in_pin;

  asbm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  asbm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign select_n     = res.select_n;
  assign serial_clock = res.serial_clock;
  assign data_out_pin = res.data_out_pin;
  assign busy_res     = res.busy_res;
  assign done_res     = res.done_res;
  assign read_data    = res.read_data;

endmodule

`default_nettype wire

// ===== hdl/asbm_checker.sv =====
// ----------------------------------------------------------------------------
// asbm_checker
// Port-level checks on the serial bus master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module asbm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        select_n,
  input wire logic        serial_clock,
  input wire logic        data_out_pin,
  input wire logic        busy_res,
  input wire logic        done_res,
  input wire logic [15:0] read_data
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_select_busy: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (select_n == !busy_res))
    else $error("chip select disagrees with busy");

  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    !empty && done_res |-> select_n && serial_clock)
    else $error("done item does not close the frame");

  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    !empty && !busy_res |-> serial_clock && !data_out_pin)
    else $error("bus lines not idle outside a frame");

  a_data_with_done: assert property (@(posedge clk) disable iff (rst)
    !empty && !done_res |-> (read_data == 16'h0000))
    else $error("read data present without done");

endmodule

bind addressed_serial_bus_master_unit asbm_checker u_asbm_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .select_n     (select_n),
  .serial_clock (serial_clock),
  .data_out_pin (data_out_pin),
  .busy_res     (busy_res),
  .done_res     (done_res),
  .read_data    (read_data)
);

`default_nettype wire

// ===== tb/addressed_serial_bus_master_unit_test.sv =====
// ----------------------------------------------------------------------------
// addressed_serial_bus_master_unit_test
// Drives the serial bus master one clock tick per item through its input
// queue. A cycle-level model of the frame sequencer predicts the pin levels,
// the status flags and the read data for every tick, and each result popped
// from the block is compared with the oldest prediction. Directed frames cover
// every action and data extremes; a random phase then mixes frames with
// ignored requests and idle ticks under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module addressed_serial_bus_master_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 920;
  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef enum logic [1:0] {
    PIN_LOW,
    PIN_HIGH,
    PIN_RANDOM
  } pin_mode_t;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_HALF,
    POP_RARE
  } pop_mode_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        start_req;
  logic [2:0]  action;
  logic [7:0]  address;
  logic [15:0] write_data;
  logic        data_in_pin;
  logic        empty;
  logic        pop;
  logic        select_n;
  logic        serial_clock;
  logic        data_out_pin;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;

  // Model of the frame sequencer.
  asbm_pkg::phase_t    bus_phase;
  logic [4:0]          bits_remaining;
  logic [23:0]         tx_shift;
  logic [15:0]         rx_shift;
  logic [2:0]          frame_action;
  logic                sclk_level;

  asbm_pkg::out_item_t expected_ticks[$];
  asbm_pkg::out_item_t oldest_tick;
  int                  error_count;
  int                  item_count;
  int                  burst_left;
  bit                  sending;
  pop_mode_t           pop_mode;
  int                  pop_mode_cycles;

  addressed_serial_bus_master_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .start_req    (start_req),
    .action       (action),
    .address      (address),
    .write_data   (write_data),
    .data_in_pin  (data_in_pin),
    .empty        (empty),
    .pop          (pop),
    .select_n     (select_n),
    .serial_clock (serial_clock),
    .data_out_pin (data_out_pin),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .read_data    (read_data)
  );

  always #10 clk = ~clk;

  task automatic step_sequencer(input asbm_pkg::in_item_t it,
                                output asbm_pkg::out_item_t res);
    logic        dbit;
    logic        done;
    logic [15:0] rdata;
    dbit  = 1'b0;
    done  = 1'b0;
    rdata = 16'h0000;
    case (bus_phase)
      asbm_pkg::PH_TX_LOW: begin
        bus_phase  = asbm_pkg::PH_TX_HIGH;
        sclk_level = 1'b1;
        dbit       = tx_shift[23];
      end
      asbm_pkg::PH_TX_HIGH: begin
        tx_shift       = tx_shift << 1;
        bits_remaining = bits_remaining - 5'd1;
        if (bits_remaining != 5'd0) begin
          bus_phase  = asbm_pkg::PH_TX_LOW;
          sclk_level = 1'b0;
          dbit       = tx_shift[23];
        end else if (frame_action == asbm_pkg::ACT_READ_BYTE ||
                     frame_action == asbm_pkg::ACT_READ_WORD) begin
          bits_remaining = (frame_action == asbm_pkg::ACT_READ_BYTE) ?
                           asbm_pkg::BITS_READ_BYTE : asbm_pkg::BITS_READ_WORD;
          bus_phase      = asbm_pkg::PH_RX_LOW;
          sclk_level     = 1'b0;
        end else begin
          bus_phase      = asbm_pkg::PH_IDLE;
          sclk_level     = 1'b1;
          bits_remaining = 5'd0;
          done           = 1'b1;
        end
      end
      asbm_pkg::PH_RX_LOW: begin
        bus_phase  = asbm_pkg::PH_RX_HIGH;
        sclk_level = 1'b1;
      end
      asbm_pkg::PH_RX_HIGH: begin
        rx_shift       = {rx_shift[14:0], it.data_in_pin};
        bits_remaining = bits_remaining - 5'd1;
        if (bits_remaining != 5'd0) begin
          bus_phase  = asbm_pkg::PH_RX_LOW;
          sclk_level = 1'b0;
        end else begin
          bus_phase      = asbm_pkg::PH_IDLE;
          sclk_level     = 1'b1;
          bits_remaining = 5'd0;
          done           = 1'b1;
          rdata          = rx_shift;
        end
      end
      default: begin
        bus_phase  = asbm_pkg::PH_IDLE;
        sclk_level = 1'b1;
        if (it.start_req && it.action <= asbm_pkg::ACT_READ_WORD) begin
          frame_action = it.action;
          rx_shift     = 16'h0000;
          case (it.action)
            asbm_pkg::ACT_WRITE_BYTE: begin
              tx_shift       = {it.address, it.write_data[7:0], 8'h00};
              bits_remaining = asbm_pkg::BITS_WRITE_BYTE;
            end
            asbm_pkg::ACT_WRITE_WORD: begin
              tx_shift       = {it.address, it.write_data};
              bits_remaining = asbm_pkg::BITS_WRITE_WORD;
            end
            default: begin
              tx_shift       = {it.address, 16'h0000};
              bits_remaining = asbm_pkg::BITS_ADDR_ONLY;
            end
          endcase
          bus_phase  = asbm_pkg::PH_TX_LOW;
          sclk_level = 1'b0;
          dbit       = tx_shift[23];
        end
      end
    endcase
    res.select_n     = (bus_phase == asbm_pkg::PH_IDLE);
    res.serial_clock = sclk_level;
    res.data_out_pin = dbit;
    res.busy_res     = (bus_phase != asbm_pkg::PH_IDLE);
    res.done_res     = done;
    res.read_data    = rdata;
  endtask

  task automatic send_item(input asbm_pkg::in_item_t it);
    asbm_pkg::out_item_t res;
    start_req   <= it.start_req;
    action      <= it.action;
    address     <= it.address;
    write_data  <= it.write_data;
    data_in_pin <= it.data_in_pin;
    push        <= 1'b1;
    sending = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    step_sequencer(it, res);
    expected_ticks.push_back(res);
    item_count++;
    burst_left--;
    if (burst_left <= 0) begin
      push <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  function automatic logic pick_pin(input pin_mode_t mode);
    case (mode)
      PIN_LOW:  return 1'b0;
      PIN_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(input logic req, input logic [2:0] act, input pin_mode_t mode);
    asbm_pkg::in_item_t it;
    it.start_req   = req;
    it.action      = act;
    it.address     = 8'($urandom_range(0, 255));
    it.write_data  = 16'($urandom_range(0, 65535));
    it.data_in_pin = pick_pin(mode);
    send_item(it);
  endtask

  // Requests arriving during the frame, closing tick included, must be ignored.
  task automatic run_frame(input logic [2:0] act, input logic [7:0] addr,
                           input logic [15:0] wdata, input pin_mode_t mode);
    asbm_pkg::in_item_t it;
    it.start_req   = 1'b1;
    it.action      = act;
    it.address     = addr;
    it.write_data  = wdata;
    it.data_in_pin = pick_pin(mode);
    send_item(it);
    while (bus_phase != asbm_pkg::PH_IDLE) begin
      send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), mode);
    end
  endtask

  task automatic test_directed_frames;
    run_frame(asbm_pkg::ACT_ADDR_ONLY, 8'hFF, 16'h0000, PIN_RANDOM);
    run_frame(asbm_pkg::ACT_ADDR_ONLY, 8'h00, 16'hFFFF, PIN_RANDOM);
    run_frame(asbm_pkg::ACT_WRITE_BYTE, 8'hA5, 16'hFF5A, PIN_RANDOM);
    run_frame(asbm_pkg::ACT_WRITE_WORD, 8'h5A, 16'hFFFF, PIN_RANDOM);
    run_frame(asbm_pkg::ACT_WRITE_WORD, 8'h80, 16'h0001, PIN_RANDOM);
    run_frame(asbm_pkg::ACT_READ_BYTE, 8'h01, 16'h0000, PIN_HIGH);
    run_frame(asbm_pkg::ACT_READ_WORD, 8'hFE, 16'h0000, PIN_HIGH);
    run_frame(asbm_pkg::ACT_READ_WORD, 8'h7F, 16'hFFFF, PIN_LOW);
    run_frame(asbm_pkg::ACT_READ_BYTE, 8'hC3, 16'h1234, PIN_RANDOM);
  endtask

  task automatic test_ignored_requests;
    send_tick(1'b1, 3'd5, PIN_RANDOM);
    send_tick(1'b1, 3'd6, PIN_RANDOM);
    send_tick(1'b1, 3'd7, PIN_RANDOM);
    send_tick(1'b0, asbm_pkg::ACT_WRITE_WORD, PIN_RANDOM);
    send_tick(1'b0, asbm_pkg::ACT_READ_WORD, PIN_RANDOM);
    run_frame(asbm_pkg::ACT_READ_WORD, 8'h3C, 16'h0000, PIN_RANDOM);
  endtask

  task automatic test_random_traffic;
    int        choice;
    int        target;
    pin_mode_t mode;
    target = item_count + RANDOM_ITEMS;
    while (item_count < target) begin
      choice = $urandom_range(0, 99);
      if (choice < 80) begin
        mode = ($urandom_range(0, 9) == 0) ? pin_mode_t'($urandom_range(0, 1)) : PIN_RANDOM;
        run_frame(3'($urandom_range(0, 4)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), mode);
      end else if (choice < 90) begin
        send_tick(1'b1, 3'($urandom_range(5, 7)), PIN_RANDOM);
      end else begin
        send_tick(1'b0, 3'($urandom_range(0, 7)), PIN_RANDOM);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time,
                   {select_n, serial_clock, data_out_pin, busy_res, done_res, read_data});
          error_count++;
        end else begin
          oldest_tick = expected_ticks.pop_front();
          compare_field("select_n", 16'(oldest_tick.select_n), 16'(select_n));
          compare_field("serial_clock", 16'(oldest_tick.serial_clock), 16'(serial_clock));
          compare_field("data_out_pin", 16'(oldest_tick.data_out_pin), 16'(data_out_pin));
          compare_field("busy_res", 16'(oldest_tick.busy_res), 16'(busy_res));
          compare_field("done_res", 16'(oldest_tick.done_res), 16'(done_res));
          compare_field("read_data", oldest_tick.read_data, read_data);
        end
      end
      if (pop_mode_cycles == 0) begin
        pop_mode        = pop_mode_t'($urandom_range(0, 2));
        pop_mode_cycles = $urandom_range(20, 120);
      end else begin
        pop_mode_cycles--;
      end
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_HALF:   pop <= 1'($urandom_range(0, 1));
        default:    pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL addressed_serial_bus_master_unit");
    $finish;
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    push            = 1'b0;
    pop             = 1'b0;
    start_req       = 1'b0;
    action          = asbm_pkg::ACT_ADDR_ONLY;
    address         = 8'h00;
    write_data      = 16'h0000;
    data_in_pin     = 1'b0;
    bus_phase       = asbm_pkg::PH_IDLE;
    bits_remaining  = 5'd0;
    tx_shift        = 24'h000000;
    rx_shift        = 16'h0000;
    frame_action    = asbm_pkg::ACT_ADDR_ONLY;
    sclk_level      = 1'b1;
    error_count     = 0;
    item_count      = 0;
    sending         = 1'b0;
    burst_left      = $urandom_range(1, 40);
    pop_mode        = POP_ALWAYS;
    pop_mode_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_ignored_requests();
    test_random_traffic();

    if (sending) push <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS addressed_serial_bus_master_unit");
    end else begin
      $display("FAIL addressed_serial_bus_master_unit");
    end
    $finish;
  end

endmodule

// ===== addressed_serial_bus_master_unit.f =====
hdl/asbm_pkg.sv
hdl/asbm_front.sv
hdl/asbm_back.sv
hdl/addressed_serial_bus_master_unit.sv
hdl/asbm_checker.sv
tb/addressed_serial_bus_master_unit_test.sv
